/* hw/rtl/epld_pkg.sv */
package epld_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int COEF_WIDTH_DEF     = 21;
    localparam int DIST_FRAC_BITS_DEF = 16;

    localparam int DIST_WIDTH       = 32;
    localparam int LINE_IN_WIDTH    = 32;
    localparam int CFG_DATA_WIDTH   = 63;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int COORD_SCALE_LOG2 = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_ZERO  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_ONE   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_TWO   = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAC_BITS = 2'd3;

    localparam logic FUNC_EPIPOLAR = 1'b0;
    localparam logic FUNC_DIRECT   = 1'b1;

    // width of the line normal coefficients a and b
    function automatic int line_width(int coord_w, int coef_w);
        return (coef_w + coord_w + 2 > LINE_IN_WIDTH) ? coef_w + coord_w + 2 : LINE_IN_WIDTH;
    endfunction

    // width of a*u + b*v + c
    function automatic int dot_width(int coord_w, int coef_w);
        return line_width(coord_w, coef_w) + coord_w + 2;
    endfunction

    // width of a*a + b*b
    function automatic int norm_sq_width(int coord_w, int coef_w);
        return 2 * line_width(coord_w, coef_w);
    endfunction

    // normal length squared times the coordinate scale squared
    function automatic int scaled_width(int coord_w, int coef_w);
        return norm_sq_width(coord_w, coef_w) + 2 * COORD_SCALE_LOG2;
    endfunction

    // running product of the partial root and the scaled norm
    function automatic int acc_width(int coord_w, int coef_w);
        return scaled_width(coord_w, coef_w) + DIST_WIDTH;
    endfunction

    // remainder of the root recurrence
    function automatic int rem_width(int coord_w, int coef_w, int frac_w);
        int num_w;
        int del_w;
        num_w = 2 * dot_width(coord_w, coef_w) + 2 * frac_w;
        del_w = acc_width(coord_w, coef_w) + DIST_WIDTH + 1;
        return (num_w > del_w) ? num_w : del_w;
    endfunction

endpackage

/* hw/rtl/epld_line.sv */
module epld_line #(
    parameter int COORD_WIDTH = epld_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = epld_pkg::COEF_WIDTH_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic [3*COEF_WIDTH-1:0]                          row_zero,
    input  logic [3*COEF_WIDTH-1:0]                          row_one,
    input  logic [3*COEF_WIDTH-1:0]                          row_two,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic                                             in_func,
    input  logic signed [COORD_WIDTH-1:0]                    in_ref_u,
    input  logic signed [COORD_WIDTH-1:0]                    in_ref_v,
    input  logic signed [COORD_WIDTH-1:0]                    in_cur_u,
    input  logic signed [COORD_WIDTH-1:0]                    in_cur_v,
    input  logic signed [epld_pkg::LINE_IN_WIDTH-1:0]        in_line_a,
    input  logic signed [epld_pkg::LINE_IN_WIDTH-1:0]        in_line_b,
    input  logic signed [epld_pkg::LINE_IN_WIDTH-1:0]        in_line_c,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic signed [epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH)-1:0] out_a,
    output logic signed [epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH)-1:0] out_b,
    output logic signed [epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH)
                         + epld_pkg::COORD_SCALE_LOG2-1:0]   out_c,
    output logic signed [COORD_WIDTH-1:0]                    out_cur_u,
    output logic signed [COORD_WIDTH-1:0]                    out_cur_v
);

    localparam int LW  = epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH);
    localparam int CLW = LW + epld_pkg::COORD_SCALE_LOG2;
    localparam int PW  = COEF_WIDTH + COORD_WIDTH;
    localparam int IW  = epld_pkg::LINE_IN_WIDTH;

    logic [3*COEF_WIDTH-1:0] rows [3];

    logic                          valid1_reg, valid2_reg;
    logic                          en1, en2;
    logic                          func_reg;
    logic signed [COORD_WIDTH-1:0] cu1_reg, cv1_reg;
    logic signed [IW-1:0]          la_reg, lb_reg, lc_reg;
    logic signed [PW-1:0]          pu_reg [3];
    logic signed [PW-1:0]          pv_reg [3];
    logic signed [COEF_WIDTH-1:0]  pc_reg [3];
    logic signed [PW-1:0]          pu_next [3];
    logic signed [PW-1:0]          pv_next [3];
    logic signed [COEF_WIDTH-1:0]  pc_next [3];

    logic signed [LW-1:0]          l3 [3];
    logic signed [LW-1:0]          a_reg, b_reg, a_next, b_next;
    logic signed [CLW-1:0]         c_reg, c_next;
    logic signed [COORD_WIDTH-1:0] cu2_reg, cv2_reg;

    assign rows[0] = row_zero;
    assign rows[1] = row_one;
    assign rows[2] = row_two;

    assign en2      = !valid2_reg || out_ready;
    assign en1      = !valid1_reg || en2;
    assign in_ready = en1;

    // matrix row times reference point, products for the first two columns, the third passed on
    always_comb begin
        logic signed [COEF_WIDTH-1:0] cf0;
        logic signed [COEF_WIDTH-1:0] cf1;
        for (int r = 0; r < 3; r++) begin
            cf0        = $signed(rows[r][0 +: COEF_WIDTH]);
            cf1        = $signed(rows[r][COEF_WIDTH +: COEF_WIDTH]);
            pc_next[r] = $signed(rows[r][2*COEF_WIDTH +: COEF_WIDTH]);
            pu_next[r] = cf0 * in_ref_u;
            pv_next[r] = cf1 * in_ref_v;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            l3[r] = LW'(pu_reg[r]) + LW'(pv_reg[r])
                  + (LW'(pc_reg[r]) <<< epld_pkg::COORD_SCALE_LOG2);
        end
        if (func_reg == epld_pkg::FUNC_DIRECT) begin
            a_next = LW'(la_reg);
            b_next = LW'(lb_reg);
            c_next = CLW'(lc_reg);
        end else begin
            a_next = l3[0];
            b_next = l3[1];
            c_next = CLW'(l3[2]) <<< epld_pkg::COORD_SCALE_LOG2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            if (en1) begin
                valid1_reg <= in_valid;
            end
            if (en2) begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            func_reg <= in_func;
            cu1_reg  <= in_cur_u;
            cv1_reg  <= in_cur_v;
            la_reg   <= in_line_a;
            lb_reg   <= in_line_b;
            lc_reg   <= in_line_c;
            for (int r = 0; r < 3; r++) begin
                pu_reg[r] <= pu_next[r];
                pv_reg[r] <= pv_next[r];
                pc_reg[r] <= pc_next[r];
            end
        end
        if (en2) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            cu2_reg <= cu1_reg;
            cv2_reg <= cv1_reg;
        end
    end

    assign out_valid = valid2_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_c     = c_reg;
    assign out_cur_u = cu2_reg;
    assign out_cur_v = cv2_reg;

endmodule

/* hw/rtl/epld_norm.sv */
module epld_norm #(
    parameter int COORD_WIDTH    = epld_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH     = epld_pkg::COEF_WIDTH_DEF,
    parameter int DIST_FRAC_BITS = epld_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH)-1:0] in_a,
    input  logic signed [epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH)-1:0] in_b,
    input  logic signed [epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH)
                         + epld_pkg::COORD_SCALE_LOG2-1:0] in_c,
    input  logic signed [COORD_WIDTH-1:0]          in_cur_u,
    input  logic signed [COORD_WIDTH-1:0]          in_cur_v,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [epld_pkg::rem_width(COORD_WIDTH, COEF_WIDTH, DIST_FRAC_BITS)-1:0] out_rem,
    output logic [epld_pkg::scaled_width(COORD_WIDTH, COEF_WIDTH)-1:0] out_scaled,
    output logic                                   out_degen
);

    localparam int LW  = epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH);
    localparam int CLW = LW + epld_pkg::COORD_SCALE_LOG2;
    localparam int MW  = LW + COORD_WIDTH;
    localparam int NW  = epld_pkg::dot_width(COORD_WIDTH, COEF_WIDTH);
    localparam int QW  = epld_pkg::norm_sq_width(COORD_WIDTH, COEF_WIDTH);
    localparam int SW  = epld_pkg::scaled_width(COORD_WIDTH, COEF_WIDTH);
    localparam int RW  = epld_pkg::rem_width(COORD_WIDTH, COEF_WIDTH, DIST_FRAC_BITS);
    localparam int AL  = LW / 2;
    localparam int AH  = LW - AL;
    localparam int NL  = NW / 2;
    localparam int NH  = NW - NL;
    localparam int ASW = 2 * LW + 1;
    localparam int NSW = 2 * NW + 1;

    logic valid3_reg, valid4_reg, valid5_reg, valid6_reg;
    logic en3, en4, en5, en6;

    // squares are split into high signed and low unsigned halves
    logic signed [AH-1:0]     ah, bh;
    logic signed [AL:0]       al, bl;
    logic signed [MW-1:0]     ma_reg, mb_reg;
    logic signed [2*AH-1:0]   ahh_reg, bhh_reg;
    logic signed [LW:0]       ahl_reg, bhl_reg;
    logic signed [2*AL+1:0]   all_reg, bll_reg;
    logic signed [CLW-1:0]    c3_reg;

    logic signed [ASW-1:0]    sq_a, sq_b;
    logic signed [NW-1:0]     n4_reg, n4_next;
    logic [QW-1:0]            q4_reg, q4_next;

    logic signed [NH-1:0]     nh;
    logic signed [NL:0]       nl;
    logic signed [2*NH-1:0]   nhh_reg;
    logic signed [NW:0]       nhl_reg;
    logic signed [2*NL+1:0]   nll_reg;
    logic [QW-1:0]            q5_reg;
    logic                     degen5_reg;

    logic signed [NSW-1:0]    nsq;
    logic [RW-1:0]            rem6_reg, rem6_next;
    logic [SW-1:0]            scaled6_reg;
    logic                     degen6_reg;

    assign en6      = !valid6_reg || out_ready;
    assign en5      = !valid5_reg || en6;
    assign en4      = !valid4_reg || en5;
    assign en3      = !valid3_reg || en4;
    assign in_ready = en3;

    assign ah = $signed(in_a[LW-1:AL]);
    assign al = $signed({1'b0, in_a[AL-1:0]});
    assign bh = $signed(in_b[LW-1:AL]);
    assign bl = $signed({1'b0, in_b[AL-1:0]});

    always_comb begin
        sq_a = (ASW'(ahh_reg) <<< (2 * AL)) + (ASW'(ahl_reg) <<< (AL + 1))
             + ASW'(all_reg);
        sq_b = (ASW'(bhh_reg) <<< (2 * AL)) + (ASW'(bhl_reg) <<< (AL + 1))
             + ASW'(bll_reg);
        n4_next = NW'(ma_reg) + NW'(mb_reg) + NW'(c3_reg);
        q4_next = QW'(sq_a + sq_b);
    end

    assign nh = $signed(n4_reg[NW-1:NL]);
    assign nl = $signed({1'b0, n4_reg[NL-1:0]});

    always_comb begin
        nsq = (NSW'(nhh_reg) <<< (2 * NL)) + (NSW'(nhl_reg) <<< (NL + 1))
            + NSW'(nll_reg);
        rem6_next = RW'(nsq[2*NW-2:0]) << (2 * DIST_FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
            valid6_reg <= 1'b0;
        end else begin
            if (en3) begin
                valid3_reg <= in_valid;
            end
            if (en4) begin
                valid4_reg <= valid3_reg;
            end
            if (en5) begin
                valid5_reg <= valid4_reg;
            end
            if (en6) begin
                valid6_reg <= valid5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            ma_reg  <= in_a * in_cur_u;
            mb_reg  <= in_b * in_cur_v;
            ahh_reg <= ah * ah;
            ahl_reg <= ah * al;
            all_reg <= al * al;
            bhh_reg <= bh * bh;
            bhl_reg <= bh * bl;
            bll_reg <= bl * bl;
            c3_reg  <= in_c;
        end
        if (en4) begin
            n4_reg <= n4_next;
            q4_reg <= q4_next;
        end
        if (en5) begin
            nhh_reg    <= nh * nh;
            nhl_reg    <= nh * nl;
            nll_reg    <= nl * nl;
            q5_reg     <= q4_reg;
            degen5_reg <= (q4_reg == '0);
        end
        if (en6) begin
            rem6_reg    <= rem6_next;
            scaled6_reg <= SW'(q5_reg) << (2 * epld_pkg::COORD_SCALE_LOG2);
            degen6_reg  <= degen5_reg;
        end
    end

    assign out_valid  = valid6_reg;
    assign out_rem    = rem6_reg;
    assign out_scaled = scaled6_reg;
    assign out_degen  = degen6_reg;

endmodule

/* hw/rtl/epld_root_stage.sv */
module epld_root_stage #(
    parameter int BIT          = 0,
    parameter int REM_WIDTH    = 160,
    parameter int ACC_WIDTH    = 120,
    parameter int SCALED_WIDTH = 88
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [REM_WIDTH-1:0]            in_rem,
    input  logic [ACC_WIDTH-1:0]            in_acc,
    input  logic [SCALED_WIDTH-1:0]         in_scaled,
    input  logic [epld_pkg::DIST_WIDTH-1:0] in_k,
    input  logic                            in_degen,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [REM_WIDTH-1:0]            out_rem,
    output logic [ACC_WIDTH-1:0]            out_acc,
    output logic [SCALED_WIDTH-1:0]         out_scaled,
    output logic [epld_pkg::DIST_WIDTH-1:0] out_k,
    output logic                            out_degen
);

    logic                            valid_reg;
    logic                            en;
    logic                            fit;
    logic [REM_WIDTH-1:0]            delta;
    logic [REM_WIDTH-1:0]            rem_reg, rem_next;
    logic [ACC_WIDTH-1:0]            acc_reg, acc_next;
    logic [SCALED_WIDTH-1:0]         scaled_reg;
    logic [epld_pkg::DIST_WIDTH-1:0] k_reg, k_next;
    logic                            degen_reg;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // (k + 2^bit)^2 * s - k^2 * s, with acc holding k * s
    assign delta = (REM_WIDTH'(in_acc) << (BIT + 1))
                 + (REM_WIDTH'(in_scaled) << (2 * BIT));
    assign fit   = (delta <= in_rem);

    always_comb begin
        rem_next  = in_rem;
        acc_next  = in_acc;
        k_next    = in_k;
        if (fit) begin
            rem_next    = in_rem - delta;
            acc_next    = in_acc + (ACC_WIDTH'(in_scaled) << BIT);
            k_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
            scaled_reg <= in_scaled;
            k_reg      <= k_next;
            degen_reg  <= in_degen;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem    = rem_reg;
    assign out_acc    = acc_reg;
    assign out_scaled = scaled_reg;
    assign out_k      = k_reg;
    assign out_degen  = degen_reg;

endmodule

/* hw/rtl/epipolar_point_line_distance_top.sv */
// pipeline: the line stages, then the residual and normal length stages, then
// one root stage per distance bit
// throughput: one item per cycle, every stage holds its item on a stall
// reset: aresetn synchronous active low, empties the pipeline and clears the
// matrix rows to zero
module epipolar_point_line_distance_top #(
    parameter int COORD_WIDTH    = epld_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH     = epld_pkg::COEF_WIDTH_DEF,
    parameter int DIST_FRAC_BITS = epld_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [epld_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [epld_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic signed [COORD_WIDTH-1:0]         s_ref_u,
    input  logic signed [COORD_WIDTH-1:0]         s_ref_v,
    input  logic signed [COORD_WIDTH-1:0]         s_cur_u,
    input  logic signed [COORD_WIDTH-1:0]         s_cur_v,
    input  logic signed [epld_pkg::LINE_IN_WIDTH-1:0] s_line_a,
    input  logic signed [epld_pkg::LINE_IN_WIDTH-1:0] s_line_b,
    input  logic signed [epld_pkg::LINE_IN_WIDTH-1:0] s_line_c,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [epld_pkg::DIST_WIDTH-1:0]       m_distance,
    output logic                                  m_status
);

    localparam int ROW_WIDTH = 3 * COEF_WIDTH;
    localparam int LW        = epld_pkg::line_width(COORD_WIDTH, COEF_WIDTH);
    localparam int CLW       = LW + epld_pkg::COORD_SCALE_LOG2;
    localparam int SW        = epld_pkg::scaled_width(COORD_WIDTH, COEF_WIDTH);
    localparam int TW        = epld_pkg::acc_width(COORD_WIDTH, COEF_WIDTH);
    localparam int RW        = epld_pkg::rem_width(COORD_WIDTH, COEF_WIDTH, DIST_FRAC_BITS);
    localparam int KW        = epld_pkg::DIST_WIDTH;

    logic [ROW_WIDTH-1:0] row_zero_reg, row_one_reg, row_two_reg;

    logic                          line_valid, line_ready;
    logic signed [LW-1:0]          line_a, line_b;
    logic signed [CLW-1:0]         line_c;
    logic signed [COORD_WIDTH-1:0] line_cur_u, line_cur_v;

    logic              valid_s [0:KW];
    logic              ready_s [0:KW];
    logic [RW-1:0]     rem_s   [0:KW];
    logic [TW-1:0]     acc_s   [0:KW];
    logic [SW-1:0]     scaled_s [0:KW];
    logic [KW-1:0]     k_s     [0:KW];
    logic              degen_s [0:KW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_zero_reg <= '0;
            row_one_reg  <= '0;
            row_two_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                epld_pkg::REG_ROW_ZERO: row_zero_reg <= cfg_data[ROW_WIDTH-1:0];
                epld_pkg::REG_ROW_ONE:  row_one_reg  <= cfg_data[ROW_WIDTH-1:0];
                epld_pkg::REG_ROW_TWO:  row_two_reg  <= cfg_data[ROW_WIDTH-1:0];
                // a common scale on the line cancels in the ratio
                epld_pkg::REG_FRAC_BITS: begin
                end
                default: begin
                end
            endcase
        end
    end

    epld_line #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_zero  (row_zero_reg),
        .row_one   (row_one_reg),
        .row_two   (row_two_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_ref_u  (s_ref_u),
        .in_ref_v  (s_ref_v),
        .in_cur_u  (s_cur_u),
        .in_cur_v  (s_cur_v),
        .in_line_a (s_line_a),
        .in_line_b (s_line_b),
        .in_line_c (s_line_c),
        .out_valid (line_valid),
        .out_ready (line_ready),
        .out_a     (line_a),
        .out_b     (line_b),
        .out_c     (line_c),
        .out_cur_u (line_cur_u),
        .out_cur_v (line_cur_v)
    );

    epld_norm #(
        .COORD_WIDTH    (COORD_WIDTH),
        .COEF_WIDTH     (COEF_WIDTH),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_norm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (line_valid),
        .in_ready   (line_ready),
        .in_a       (line_a),
        .in_b       (line_b),
        .in_c       (line_c),
        .in_cur_u   (line_cur_u),
        .in_cur_v   (line_cur_v),
        .out_valid  (valid_s[0]),
        .out_ready  (ready_s[0]),
        .out_rem    (rem_s[0]),
        .out_scaled (scaled_s[0]),
        .out_degen  (degen_s[0])
    );

    assign acc_s[0] = '0;
    assign k_s[0]   = '0;

    // one distance bit per stage, most significant first
    for (genvar i = 0; i < KW; i++) begin : g_root
        epld_root_stage #(
            .BIT          (KW - 1 - i),
            .REM_WIDTH    (RW),
            .ACC_WIDTH    (TW),
            .SCALED_WIDTH (SW)
        ) u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (valid_s[i]),
            .in_ready   (ready_s[i]),
            .in_rem     (rem_s[i]),
            .in_acc     (acc_s[i]),
            .in_scaled  (scaled_s[i]),
            .in_k       (k_s[i]),
            .in_degen   (degen_s[i]),
            .out_valid  (valid_s[i+1]),
            .out_ready  (ready_s[i+1]),
            .out_rem    (rem_s[i+1]),
            .out_acc    (acc_s[i+1]),
            .out_scaled (scaled_s[i+1]),
            .out_k      (k_s[i+1]),
            .out_degen  (degen_s[i+1])
        );
    end

    assign ready_s[KW] = m_ready;
    assign m_valid     = valid_s[KW];
    assign m_distance  = degen_s[KW] ? '0 : k_s[KW];
    assign m_status    = degen_s[KW];

endmodule

/* tb/sv/epipolar_point_line_distance_top_tb.sv */
`timescale 1ns / 1ps

module epipolar_point_line_distance_top_tb;

    localparam int COORD_W     = epld_pkg::COORD_WIDTH_DEF;
    localparam int COEF_W      = epld_pkg::COEF_WIDTH_DEF;
    localparam int LINE_W      = epld_pkg::LINE_IN_WIDTH;
    localparam int DIST_W      = epld_pkg::DIST_WIDTH;
    localparam int IDX_W       = epld_pkg::CFG_INDEX_WIDTH;
    localparam int CFG_W       = epld_pkg::CFG_DATA_WIDTH;
    localparam int FRAC_W      = epld_pkg::DIST_FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [IDX_W-1:0] ROW_REGS [3] = '{epld_pkg::REG_ROW_ZERO,
                                                  epld_pkg::REG_ROW_ONE,
                                                  epld_pkg::REG_ROW_TWO};

    typedef struct {
        logic                      func;
        logic signed [COORD_W-1:0] ref_u;
        logic signed [COORD_W-1:0] ref_v;
        logic signed [COORD_W-1:0] cur_u;
        logic signed [COORD_W-1:0] cur_v;
        logic signed [LINE_W-1:0]  line_a;
        logic signed [LINE_W-1:0]  line_b;
        logic signed [LINE_W-1:0]  line_c;
    } point_item_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              status;
    } distance_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [IDX_W-1:0]                  cfg_index;
    logic [CFG_W-1:0]                  cfg_data;
    logic                              s_valid;
    logic                              s_ready;
    logic                              s_func;
    logic signed [COORD_W-1:0]         s_ref_u;
    logic signed [COORD_W-1:0]         s_ref_v;
    logic signed [COORD_W-1:0]         s_cur_u;
    logic signed [COORD_W-1:0]         s_cur_v;
    logic signed [LINE_W-1:0]          s_line_a;
    logic signed [LINE_W-1:0]          s_line_b;
    logic signed [LINE_W-1:0]          s_line_c;
    logic                              m_valid;
    logic                              m_ready;
    logic [DIST_W-1:0]                 m_distance;
    logic                              m_status;

    logic [CFG_W-1:0]          matrix_rows [3];
    logic [4:0]                frac_bits;
    distance_t                 pending_distances [$];
    int                        error_count;
    int                        sender_idle_pct;
    int                        receiver_idle_pct;
    int                        stall_cycles = 0;

    epipolar_point_line_distance_top i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_ref_u    (s_ref_u),
        .s_ref_v    (s_ref_v),
        .s_cur_u    (s_cur_u),
        .s_cur_v    (s_cur_v),
        .s_line_a   (s_line_a),
        .s_line_b   (s_line_b),
        .s_line_c   (s_line_c),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance),
        .m_status   (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint matrix_coef(int row, int col);
        logic signed [COEF_W-1:0] c;
        c = matrix_rows[row][col*COEF_W +: COEF_W];
        return longint'(c);
    endfunction

    // exact |a*u+b*v+c| / sqrt(a^2+b^2) times 2^FRAC_W / 16, truncated, saturating
    function automatic distance_t predict_distance(point_item_t it);
        longint           la, lb, lc, ln, l3 [3];
        logic [63:0]      abs_a, abs_b, abs_n;
        logic [127:0]     norm_sq;
        logic [255:0]     num, den, prod;
        logic [31:0]      k, cand;
        distance_t        r;
        if (it.func != epld_pkg::FUNC_DIRECT) begin
            for (int row = 0; row < 3; row++)
                l3[row] = matrix_coef(row, 0) * longint'(it.ref_u)
                        + matrix_coef(row, 1) * longint'(it.ref_v)
                        + matrix_coef(row, 2) * 16;
            la = l3[0];
            lb = l3[1];
            lc = l3[2] * 16;
        end else begin
            la = longint'(it.line_a);
            lb = longint'(it.line_b);
            lc = longint'(it.line_c);
        end
        ln = la * longint'(it.cur_u) + lb * longint'(it.cur_v) + lc;
        abs_a = (la < 0) ? -la : la;
        abs_b = (lb < 0) ? -lb : lb;
        abs_n = (ln < 0) ? -ln : ln;
        norm_sq = {64'b0, abs_a} * {64'b0, abs_a} + {64'b0, abs_b} * {64'b0, abs_b};
        r.distance = '0;
        r.status   = 1'b1;
        if (norm_sq == 0) return r;
        num = ({192'b0, abs_n} * {192'b0, abs_n}) << (2 * FRAC_W);
        den = {128'b0, norm_sq} << 8;
        k = '0;
        for (int bit_i = 31; bit_i >= 0; bit_i--) begin
            cand = k | (32'd1 << bit_i);
            prod = {224'b0, cand} * {224'b0, cand} * den;
            if (prod <= num) k = cand;
        end
        r.distance = k;
        r.status   = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        distance_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_distances.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_distance), 64'd0);
            end else begin
                want = pending_distances.pop_front();
                if (m_distance !== want.distance)
                    report_mismatch("distance", 64'(m_distance), 64'(want.distance));
                if (m_status !== want.status)
                    report_mismatch("status", 64'(m_status), 64'(want.status));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn)
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("epipolar_point_line_distance_top verification failed");
            $finish;
        end
    end

    task automatic send_item(point_item_t it);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_func   <= it.func;
        s_ref_u  <= it.ref_u;
        s_ref_v  <= it.ref_v;
        s_cur_u  <= it.cur_u;
        s_cur_v  <= it.cur_v;
        s_line_a <= it.line_a;
        s_line_b <= it.line_b;
        s_line_c <= it.line_c;
        do @(posedge aclk); while (!s_ready);
        pending_distances.push_back(predict_distance(it));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == epld_pkg::REG_FRAC_BITS)
            frac_bits = val[4:0];
        else
            matrix_rows[idx] = val;
    endtask

    function automatic logic [COEF_W-1:0] random_coef();
        logic signed [COEF_W-1:0] c;
        c = COEF_W'($urandom);
        return c >>> $urandom_range(COEF_W - 1, 0);
    endfunction

    task automatic write_matrix(int pick);
        logic [CFG_W-1:0] row;
        int               fb;
        for (int i = 0; i < 3; i++) begin
            unique case (pick)
                0: row = '0;
                1: row = {3{21'h100000}};
                2: row = {3{21'h0FFFFF}};
                default: row = {random_coef(), random_coef(), random_coef()};
            endcase
            write_reg(ROW_REGS[i], row);
        end
        fb = (pick == 1) ? 20 : (pick == 0) ? 0 : int'($urandom_range(20));
        write_reg(epld_pkg::REG_FRAC_BITS, CFG_W'(fb));
    endtask

    function automatic point_item_t random_item();
        point_item_t it;
        it.func   = ($urandom_range(99) < 45) ? epld_pkg::FUNC_DIRECT
                                               : epld_pkg::FUNC_EPIPOLAR;
        it.ref_u  = COORD_W'($urandom);
        it.ref_v  = COORD_W'($urandom);
        it.cur_u  = COORD_W'($urandom);
        it.cur_v  = COORD_W'($urandom);
        it.line_a = $signed($urandom) >>> $urandom_range(31, 0);
        it.line_b = $signed($urandom) >>> $urandom_range(31, 0);
        it.line_c = $signed($urandom) >>> $urandom_range(31, 0);
        if ($urandom_range(99) < 8) begin
            it.line_a = '0;
            it.line_b = '0;
        end
        return it;
    endfunction

    function automatic point_item_t direct_line(int a, int b, int c, int u, int v);
        point_item_t it;
        it = '{epld_pkg::FUNC_DIRECT, 16'sh7FFF, 16'sh8000, COORD_W'(u), COORD_W'(v),
               a, b, c};
        return it;
    endfunction

    task automatic test_degenerate_lines();
        send_item(direct_line(0, 0, 0, 0, 0));
        send_item(direct_line(0, 0, 32'h7FFFFFFF, 16'sh7FFF, 16'sh8000));
        send_item('{epld_pkg::FUNC_EPIPOLAR, 16'sh1234, -16'sh4321, 16'sh0100, 16'sh0010,
                    1, 2, 3});
    endtask

    task automatic test_direct_extremes();
        send_item(direct_line(1, 0, 0, 16'sh0010, 0));
        send_item(direct_line(0, 1, -16, 0, 16'sh7FFF));
        send_item(direct_line(32'h80000000, 32'h80000000, 32'h80000000, 16'sh8000, 16'sh8000));
        send_item(direct_line(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'sh7FFF, 16'sh7FFF));
        // huge residual on a tiny normal saturates
        send_item(direct_line(1, 0, 32'h7FFFFFFF, 16'sh7FFF, 0));
        send_item(direct_line(-1, 1, 32'h80000000, 16'sh8000, 16'sh7FFF));
        send_item(direct_line(3, 4, 5, -16'sh0001, 16'sh0002));
        send_item(direct_line(32'h7FFFFFFF, 1, 0, 0, 16'sh7FFF));
        send_item(direct_line(-7, 0, 0, 16'sh0001, -16'sh7000));
    endtask

    task automatic test_epipolar_extremes();
        point_item_t it;
        for (int pick = 1; pick <= 3; pick++) begin
            wait_for_results();
            write_matrix(pick);
            for (int i = 0; i < 4; i++) begin
                it = '{epld_pkg::FUNC_EPIPOLAR,
                       (i[0] ? 16'sh7FFF : 16'sh8000), (i[1] ? 16'sh8000 : 16'sh7FFF),
                       (i[1] ? 16'sh7FFF : -16'sh0010), (i[0] ? 16'sh0000 : 16'sh8000),
                       32'h7FFFFFFF, 32'h80000000, 32'h55555555};
                send_item(it);
            end
        end
    endtask

    task automatic test_random_stream(int count, bit hold_off);
        for (int i = 0; i < count; i++) begin
            // hold off until the pipeline has emptied once per phase
            if (hold_off && i == count / 2) wait_for_results();
            send_item(random_item());
        end
    endtask

    initial begin
        error_count       = 0;
        sender_idle_pct   = 24;
        receiver_idle_pct = 86;
        matrix_rows       = '{default: '0};
        frac_bits         = '0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_func    <= 1'b0;
        s_ref_u   <= '0;
        s_ref_v   <= '0;
        s_cur_u   <= '0;
        s_cur_v   <= '0;
        s_line_a  <= '0;
        s_line_b  <= '0;
        s_line_c  <= '0;
        m_ready   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_degenerate_lines();
        test_direct_extremes();
        test_epipolar_extremes();

        wait_for_results();
        write_matrix(3);
        test_random_stream(215, 1'b1);

        wait_for_results();
        sender_idle_pct   = 86;
        receiver_idle_pct = 24;
        write_matrix(2);
        write_matrix(3);
        test_random_stream(215, 1'b1);

        wait_for_results();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_matrix(0);
        write_matrix(3);
        test_random_stream(215, 1'b0);

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("epipolar_point_line_distance_top verification clean");
        else
            $display("epipolar_point_line_distance_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/epld_pkg.sv
hw/rtl/epld_line.sv
hw/rtl/epld_norm.sv
hw/rtl/epld_root_stage.sv
hw/rtl/epipolar_point_line_distance_top.sv
tb/sv/epipolar_point_line_distance_top_tb.sv
